>>> src/rmc_pkg.sv
// Shared types, character codes and digit helpers for the RMC time parser.
package rmc_pkg;

   // Widths of the time fields and of one received byte
   localparam int TIME_W     = 7;
   localparam int BYTE_W     = 8;
   localparam int HEADER_LEN = 5;

   // Characters that steer the parser
   localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CHAR_COMMA  = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_A      = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;

   // Wrap limits of the clock and the upper clamp of a digit pair
   localparam logic [TIME_W-1:0] SEC_WRAP   = 7'd60;
   localparam logic [TIME_W-1:0] MIN_WRAP   = 7'd60;
   localparam logic [TIME_W-1:0] HOUR_WRAP  = 7'd24;
   localparam logic [TIME_W-1:0] PAIR_MAX   = 7'd99;

   // Input selector
   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   // Sentence parser: header letters matched so far, then the body
   typedef enum logic [2:0] {
      PS_IDLE = 3'd0,
      PS_HDR1 = 3'd1,
      PS_HDR2 = 3'd2,
      PS_HDR3 = 3'd3,
      PS_HDR4 = 3'd4,
      PS_HDR5 = 3'd5,
      PS_BODY = 3'd6
   } parse_state_type;

   // Comma counts inside the body
   localparam logic [1:0] COMMA_NONE = 2'd0;
   localparam logic [1:0] COMMA_ONE  = 2'd1;
   localparam logic [1:0] COMMA_TWO  = 2'd2;

   // Classified item handed from the front end to the back end
   typedef struct packed {
      logic                  is_tick;
      logic                  is_dollar;
      logic                  is_comma;
      logic                  is_a;
      logic [HEADER_LEN-1:0] hdr_hit;
      logic [BYTE_W-1:0]     data;
   } item_type;

   // Letters of the sentence header, first letter at index 0
   function automatic logic [BYTE_W-1:0] header_char(input logic [2:0] idx);
      logic [BYTE_W-1:0] ch;
      case (idx)
         3'd0:    ch = 8'h47; // G
         3'd1:    ch = 8'h50; // P
         3'd2:    ch = 8'h52; // R
         3'd3:    ch = 8'h4D; // M
         3'd4:    ch = 8'h43; // C
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Two ASCII digits to a value, tens*10 + units, clamped to 0..99
   function automatic logic [TIME_W-1:0] digit_pair(input logic [BYTE_W-1:0] tens_ch,
                                                    input logic [BYTE_W-1:0] unit_ch);
      logic signed [12:0] tens_v;
      logic signed [12:0] unit_v;
      logic signed [12:0] sum_v;
      logic [TIME_W-1:0]  res;
      tens_v = $signed({5'd0, tens_ch}) - $signed({5'd0, CHAR_ZERO});
      unit_v = $signed({5'd0, unit_ch}) - $signed({5'd0, CHAR_ZERO});
      sum_v  = (tens_v <<< 3) + (tens_v <<< 1) + unit_v;
      if (sum_v < 13'sd0) begin
         res = '0;
      end else if (sum_v > $signed({6'd0, PAIR_MAX})) begin
         res = PAIR_MAX;
      end else begin
         res = sum_v[TIME_W-1:0];
      end
      return res;
   endfunction

endpackage

>>> src/rmc_front.sv
// Front end: takes input items and classifies each byte for the back end.
module rmc_front (
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // [7:0] rx_byte
   input  logic                           req_tuser,  // [0] opcode
   input  logic                           q_ready,
   output logic                           q_push,
   output rmc_pkg::item_type              q_item
);

   // Items flow straight into the queue while it has room
   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready;

   // Byte classification, including a hit per header letter
   always_comb begin
      q_item           = '0;
      q_item.is_tick   = (rmc_pkg::opcode_type'(req_tuser) == rmc_pkg::OP_TICK);
      q_item.is_dollar = (req_tdata == rmc_pkg::CHAR_DOLLAR);
      q_item.is_comma  = (req_tdata == rmc_pkg::CHAR_COMMA);
      q_item.is_a      = (req_tdata == rmc_pkg::CHAR_A);
      q_item.data      = req_tdata;
      for (int i = 0; i < rmc_pkg::HEADER_LEN; i++) begin
         q_item.hdr_hit[i] = (req_tdata == rmc_pkg::header_char(3'(i)));
      end
   end

endmodule

>>> src/rmc_queue.sv
// Two-entry queue between the classifying front end and the back end.
module rmc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rmc_pkg::item_type push_item,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output rmc_pkg::item_type pop_item
);

   rmc_pkg::item_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/rmc_back.sv
// Back end: sentence parser, seconds clock and the result register.
module rmc_back #(
   parameter int HISTORY_DEPTH = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  rmc_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata
);

   localparam int TW       = rmc_pkg::TIME_W;
   localparam int TAP_LO   = 4;
   localparam int TAP_HI   = 9;

   rmc_pkg::parse_state_type state_ff, state_in;
   logic [1:0]    comma_ff, comma_in;
   logic          fix_ff, fix_in;
   logic          ready_ff, ready_in;
   logic          colon_ff, colon_in;
   logic [TW-1:0] hour_ff, hour_in;
   logic [TW-1:0] min_ff, min_in;
   logic [TW-1:0] sec_ff, sec_in;
   logic [7:0]    hist_ff [HISTORY_DEPTH];
   logic [7:0]    hist_in [HISTORY_DEPTH];
   logic          rsp_valid_ff, rsp_valid_in;
   logic [23:0]   rsp_data_ff, rsp_data_in;

   logic          out_free, take, tick_take, byte_take, body_byte;
   logic          hist_clear, hist_shift, load_time, out_load;
   logic [TW-1:0] sec_inc, min_inc, hour_inc;
   logic [7:0]    tap [TAP_LO:TAP_HI];

   // Result register frees itself when taken, so one item each cycle while it is empty or rsp_tready is high
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign take      = q_valid && out_free;
   assign q_pop     = take;
   assign tick_take = take && q_item.is_tick;
   assign byte_take = take && !q_item.is_tick && !ready_ff;
   assign body_byte = byte_take && !q_item.is_dollar && (state_ff == rmc_pkg::PS_BODY);

   // History taps that hold the time digits; missing taps read as zero
   for (genvar g = TAP_LO; g <= TAP_HI; g++) begin : g_tap
      if (g < HISTORY_DEPTH) begin : g_have
         assign tap[g] = hist_ff[g];
      end else begin : g_none
         assign tap[g] = '0;
      end
   end

   // Parser next state
   always_comb begin
      state_in = state_ff;
      if (byte_take) begin
         if (q_item.is_dollar) begin
            state_in = rmc_pkg::PS_HDR1;
         end else begin
            unique case (state_ff)
               rmc_pkg::PS_HDR1: state_in = q_item.hdr_hit[0] ? rmc_pkg::PS_HDR2
                                                               : rmc_pkg::PS_IDLE;
               rmc_pkg::PS_HDR2: state_in = q_item.hdr_hit[1] ? rmc_pkg::PS_HDR3
                                                               : rmc_pkg::PS_IDLE;
               rmc_pkg::PS_HDR3: state_in = q_item.hdr_hit[2] ? rmc_pkg::PS_HDR4
                                                               : rmc_pkg::PS_IDLE;
               rmc_pkg::PS_HDR4: state_in = q_item.hdr_hit[3] ? rmc_pkg::PS_HDR5
                                                               : rmc_pkg::PS_IDLE;
               rmc_pkg::PS_HDR5: state_in = q_item.hdr_hit[4] ? rmc_pkg::PS_BODY
                                                               : rmc_pkg::PS_IDLE;
               rmc_pkg::PS_BODY: begin
                  if (comma_ff == rmc_pkg::COMMA_TWO && q_item.is_comma) begin
                     state_in = rmc_pkg::PS_IDLE;
                  end
               end
               default: state_in = rmc_pkg::PS_IDLE;
            endcase
         end
      end
   end

   // Parser actions: commas, fix flag, history, time load
   always_comb begin
      comma_in   = comma_ff;
      fix_in     = fix_ff;
      ready_in   = ready_ff;
      hist_clear = byte_take && q_item.is_dollar;
      hist_shift = 1'b0;
      load_time  = 1'b0;
      if (hist_clear) begin
         comma_in = rmc_pkg::COMMA_NONE;
         fix_in   = 1'b0;
      end else if (body_byte) begin
         if (comma_ff == rmc_pkg::COMMA_TWO) begin
            if (q_item.is_comma) begin
               // status field closed: clock is ready and results start from here on
               load_time = fix_ff;
               ready_in  = 1'b1;
               comma_in  = rmc_pkg::COMMA_NONE;
            end else begin
               fix_in = q_item.is_a;
            end
         end else if (q_item.is_comma && comma_ff == rmc_pkg::COMMA_ONE) begin
            // time field closed: history freezes
            comma_in = rmc_pkg::COMMA_TWO;
         end else begin
            hist_shift = 1'b1;
            if (q_item.is_comma) begin
               comma_in = comma_ff + 2'd1;
            end
         end
      end
   end

   // History shift line, newest byte at entry zero
   always_comb begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         if (hist_clear) begin
            hist_in[i] = '0;
         end else if (hist_shift) begin
            hist_in[i] = (i == 0) ? q_item.data : hist_ff[(i == 0) ? 0 : i - 1];
         end else begin
            hist_in[i] = hist_ff[i];
         end
      end
   end

   // Seconds clock: tick carries through 60/60/24, or a parsed time loads
   always_comb begin
      sec_inc  = sec_ff + 7'd1;
      min_inc  = min_ff + 7'd1;
      hour_inc = hour_ff + 7'd1;
      hour_in  = hour_ff;
      min_in   = min_ff;
      sec_in   = sec_ff;
      colon_in = colon_ff;
      if (tick_take) begin
         sec_in = sec_inc;
         if (sec_inc >= rmc_pkg::SEC_WRAP) begin
            sec_in = '0;
            min_in = min_inc;
            if (min_inc >= rmc_pkg::MIN_WRAP) begin
               min_in  = '0;
               hour_in = (hour_inc >= rmc_pkg::HOUR_WRAP) ? '0 : hour_inc;
            end
         end
         if (ready_ff) begin
            colon_in = !colon_ff;
         end
      end else if (load_time) begin
         sec_in  = rmc_pkg::digit_pair(tap[5], tap[4]);
         min_in  = rmc_pkg::digit_pair(tap[7], tap[6]);
         hour_in = rmc_pkg::digit_pair(tap[9], tap[8]);
      end
   end

   // Result register
   assign out_load = tick_take && ready_ff;
   always_comb begin
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_data_in = {1'b0, fix_ff, colon_in, sec_in, min_in, hour_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rmc_pkg::PS_IDLE;
         comma_ff     <= rmc_pkg::COMMA_NONE;
         fix_ff       <= 1'b0;
         ready_ff     <= 1'b0;
         colon_ff     <= 1'b0;
         hour_ff      <= '0;
         min_ff       <= '0;
         sec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         comma_ff     <= comma_in;
         fix_ff       <= fix_in;
         ready_ff     <= ready_in;
         colon_ff     <= colon_in;
         hour_ff      <= hour_in;
         min_ff       <= min_in;
         sec_ff       <= sec_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= hist_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Once the clock is ready it stays ready
   a_ready_sticky: assert property (@(posedge clock) disable iff (reset)
      ready_ff |=> ready_ff)
      else $error("clock ready flag dropped");

   // Comma count is only non-zero inside a sentence body
   a_comma_body: assert property (@(posedge clock) disable iff (reset)
      (comma_ff != rmc_pkg::COMMA_NONE) |-> (state_ff == rmc_pkg::PS_BODY))
      else $error("comma count outside sentence body");

   // A result only ever comes from a tick while ready
   a_result_src: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (q_item.is_tick && ready_ff && q_valid))
      else $error("result loaded without a ready tick");

   // Seconds in a fresh result are always below the wrap
   a_sec_range: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (rsp_data_ff[20:14] < rmc_pkg::SEC_WRAP))
      else $error("seconds out of range in result");

endmodule

>>> src/rmc_time_parser_pps_clock.sv
// Top level: GPS sentence time parser driving a seconds clock from PPS ticks.
// Throughput: one item per cycle on req_, sustained with rsp_tready held high.
// A ready tick's result is registered and shown on rsp_ in the cycle after the back end
//   takes it from the two-entry queue that registers each accepted item.
// Ticks before the clock is ready and all bytes give no result.
// Reset: synchronous, clears the time, colon, fix and ready flags, parser and history.
module rmc_time_parser_pps_clock #(
   parameter int HISTORY_DEPTH = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [6:0] hour_value, [13:7] minute_value,
                                    // [20:14] second_value, [21] colon_on,
                                    // [22] fix_was_valid, [23] zero
);

   logic              push, push_ready, pop, pop_valid;
   rmc_pkg::item_type push_item, pop_item;

   rmc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_ready    (push_ready),
      .q_push     (push),
      .q_item     (push_item)
   );

   rmc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_item   (pop_item)
   );

   rmc_back #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (pop_valid),
      .q_item     (pop_item),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
